// ----- hdl/int4_group_dequant_mac_defines.svh -----
// Assertion macros shared by the int4 group dequant MAC RTL.
// No dependencies; the using module must have clk_i and rst_ni in scope.
`ifndef INT4_GROUP_DEQUANT_MAC_DEFINES_SVH
`define INT4_GROUP_DEQUANT_MAC_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IDQM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define IDQM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/idqm_pkg.sv -----
// Package for the int4 group dequant MAC: item types, control structs, constants.
// No dependencies.
`default_nettype none

package idqm_pkg;

  localparam int ACC_BITS_DEF = 64;
  localparam int NIBBLE_W     = 4;
  localparam int ZP_W         = 12;
  localparam int SCALE_W      = 24;
  localparam int PROD_W       = 21;   // int8 * signed Q.8 diff
  localparam int TERM_W       = 45;   // PROD_W * unsigned Q8.16 scale
  localparam int MAG_W        = 64;   // magnitude split into two 32-bit halves
  localparam int PADDR_W      = 3;

  localparam logic [ZP_W-1:0]    ZP_FIXED        = 12'd2048;  // 8.0 in Q4.8
  localparam logic [SCALE_W-1:0] ACT_SCALE_RESET = 24'd65536; // 1.0 in Q8.16
  localparam logic [31:0]        Q16_MAX         = 32'h7FFF_FFFF;
  localparam logic [31:0]        Q16_MIN         = 32'h8000_0000;

  // register index, taken from paddr[2]
  localparam logic REG_USE_ZP    = 1'b0;
  localparam logic REG_ACT_SCALE = 1'b1;

  typedef struct packed {
    logic signed [7:0]  act_even;
    logic signed [7:0]  act_odd;
    logic [7:0]         packed_weight;
    logic               odd_valid;
    logic [SCALE_W-1:0] group_scale;
    logic [ZP_W-1:0]    group_zero_point;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD_EVEN,
    ST_ADD_ODD,
    ST_SCALE_MAG,
    ST_SCALE_MUL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;   // capture operands, form x * (w - zp)
    logic mul;    // multiply by the group scale
  } lane_ctrl_t;

  typedef struct packed {
    logic add;
    logic sel_odd;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic mag_en;
    logic mul_en;
  } scale_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/idqm_lane.sv -----
// One MAC lane: dequantizes a 4-bit weight and forms x * (w - zp) * scale.
// Depends on idqm_pkg.
`default_nettype none

module idqm_lane import idqm_pkg::*; (
  input  wire logic                     clk_i,
  input  wire lane_ctrl_t               ctrl_i,
  input  wire logic signed [7:0]        act_i,
  input  wire logic [NIBBLE_W-1:0]      weight_i,
  input  wire logic [ZP_W-1:0]          zero_point_i,
  input  wire logic [SCALE_W-1:0]       scale_i,
  input  wire logic                     keep_i,
  output logic signed [TERM_W-1:0]      term_o
);

  logic signed [ZP_W:0]       diff;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic [SCALE_W-1:0]         scale_q;
  logic                       keep_q;
  logic signed [TERM_W-1:0]   term_d, term_q;

  // weight taken as Q4.8, so the difference is exact in Q.8
  assign diff   = signed'({1'b0, weight_i, 8'h00}) - signed'({1'b0, zero_point_i});
  assign prod_d = act_i * diff;
  // kept as a pure signed product; the skip is applied at the register
  assign term_d = prod_q * signed'({1'b0, scale_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q  <= prod_d;
      scale_q <= scale_i;
      keep_q  <= keep_i;
    end
    if (ctrl_i.mul) begin
      term_q <= keep_q ? term_d : '0;
    end
  end

  assign term_o = term_q;

endmodule

`default_nettype wire

// ----- hdl/idqm_acc.sv -----
// Merge stage: saturating accumulator that folds in the even then the odd lane term.
// Depends on idqm_pkg.
`default_nettype none

module idqm_acc import idqm_pkg::*; #(
  parameter int ACC_BITS = ACC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire acc_ctrl_t                ctrl_i,
  input  wire logic signed [TERM_W-1:0] term_even_i,
  input  wire logic signed [TERM_W-1:0] term_odd_i,
  output logic signed [ACC_BITS-1:0]    acc_o
);

  localparam logic [ACC_BITS-1:0] AccMax = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic [ACC_BITS-1:0] AccMin = {1'b1, {(ACC_BITS-1){1'b0}}};

  logic signed [ACC_BITS-1:0] acc_d, acc_q;
  logic signed [TERM_W-1:0]   term_sel;
  logic signed [ACC_BITS:0]   sum;

  assign term_sel = ctrl_i.sel_odd ? term_odd_i : term_even_i;
  assign sum      = (ACC_BITS+1)'(acc_q) + (ACC_BITS+1)'(term_sel);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.add) begin
      // one guard bit: the top two differ only on overflow
      if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
        acc_d = sum[ACC_BITS] ? signed'(AccMin) : signed'(AccMax);
      end else begin
        acc_d = sum[ACC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ----- hdl/idqm_scale.sv -----
// Final scaling: |acc| * activation scale as two 32x24 products, then
// rounding toward minus infinity and saturation to Q16.16. Depends on idqm_pkg.
`default_nettype none

module idqm_scale import idqm_pkg::*; #(
  parameter int ACC_BITS = ACC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire scale_ctrl_t              ctrl_i,
  input  wire logic signed [ACC_BITS-1:0] acc_i,
  input  wire logic [SCALE_W-1:0]       act_scale_i,
  output logic [31:0]                   result_o,
  output logic                          saturated_o
);

  localparam int HALF_W = MAG_W / 2;
  localparam int PP_W   = HALF_W + SCALE_W;
  localparam int Q_W    = HALF_W + 9;

  logic [ACC_BITS-1:0] acc_u, mag_d;
  logic [MAG_W-1:0]    mag_q;
  logic                neg_q;
  logic [PP_W-1:0]     hi_q, lo_q;
  logic                hi_ovf, rnd;
  logic [Q_W-1:0]      q;
  logic [31:0]         q32;
  logic                sat;

  assign acc_u = acc_i;
  assign mag_d = acc_i[ACC_BITS-1] ? ((~acc_u) + ACC_BITS'(1)) : acc_u;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mag_en) begin
      mag_q <= MAG_W'(mag_d);
      neg_q <= acc_i[ACC_BITS-1];
    end
    if (ctrl_i.mul_en) begin
      hi_q <= mag_q[MAG_W-1:HALF_W] * act_scale_i;
      lo_q <= mag_q[HALF_W-1:0] * act_scale_i;
    end
  end

  assign hi_ovf = |hi_q[PP_W-1:HALF_W];
  // negative values round away from zero in magnitude, i.e. floor
  assign rnd    = neg_q && (|lo_q[SCALE_W-1:0]);
  assign q      = Q_W'({hi_q[HALF_W-1:0], 8'h00}) + Q_W'(lo_q[PP_W-1:SCALE_W]) + Q_W'(rnd);
  assign q32    = q[31:0];

  always_comb begin
    if (!neg_q) begin
      sat      = hi_ovf || (|q[Q_W-1:31]);
      result_o = sat ? Q16_MAX : q32;
    end else begin
      sat      = hi_ovf || (|q[Q_W-1:32]) || (q[31] && (|q[30:0]));
      result_o = sat ? Q16_MIN : ((~q32) + 32'd1);
    end
  end

  assign saturated_o = sat;

endmodule

`default_nettype wire

// ----- hdl/int4_group_dequant_mac.sv -----
// int4_group_dequant_mac: W4A8 group-quantized dot product, one output element.
// Depends on idqm_pkg, idqm_lane, idqm_acc, idqm_scale and the defines header.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): each item is one pair of
// int8 activations with their packed 4-bit weights and the group scale and
// zero point. Two lanes dequantize and multiply the pair side by side, and the
// accumulator folds in the even term, then the odd term, each with saturation.
// An item passes through the two-stage lane multiply and the accumulator's two
// sequential saturating adds; in_stall_o is high while an item is in progress,
// so the next item is taken only once the block is back in ST_IDLE.
// On an item with last set, ST_SCALE_MAG, ST_SCALE_MUL and ST_EMIT take the
// magnitude, form the two 32x24 partial products with the activation scale and
// round/saturate into the output register that drives out_valid_o, and the
// accumulator clears as it is loaded.
// The output register holds while out_stall_i is high; the block keeps taking
// items and only waits in its final step if the previous result is still held.
// Config (APB, pready tied high): 0x0 use_zero_point, 0x4 activation_scale.
// Reset clears the accumulator, drops any result and restores register defaults.
`default_nettype none

`include "int4_group_dequant_mac_defines.svh"

module int4_group_dequant_mac import idqm_pkg::*; #(
  parameter int ACC_BITS = ACC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_item_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_item_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  state_e                     state_q, state_d;
  logic                       use_zp_q;
  logic [SCALE_W-1:0]         act_scale_q;
  logic                       last_q;
  logic                       in_accept, cfg_write, out_free, emit_load;
  logic [ZP_W-1:0]            zp_sel;
  lane_ctrl_t                 lane_ctrl;
  acc_ctrl_t                  acc_ctrl;
  scale_ctrl_t                scale_ctrl;
  logic signed [TERM_W-1:0]   term_even, term_odd;
  logic signed [ACC_BITS-1:0] acc_val;
  logic [31:0]                scale_result;
  logic                       scale_sat;
  logic                       out_valid_q;
  out_item_t                  out_item_q;

  // ---------------- config port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_zp_q    <= 1'b0;
      act_scale_q <= ACT_SCALE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_USE_ZP:    use_zp_q    <= pwdata[0];
        REG_ACT_SCALE: act_scale_q <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_USE_ZP:    prdata = {31'd0, use_zp_q};
      REG_ACT_SCALE: prdata = {8'd0, act_scale_q};
      default:       prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign zp_sel     = use_zp_q ? in_item_i.group_zero_point : ZP_FIXED;

  always_comb begin
    state_d    = state_q;
    lane_ctrl  = '0;
    acc_ctrl   = '0;
    scale_ctrl = '0;
    emit_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        lane_ctrl.load = in_accept;
        if (in_accept) state_d = ST_MUL;
      end
      ST_MUL: begin
        lane_ctrl.mul = 1'b1;
        state_d       = ST_ADD_EVEN;
      end
      ST_ADD_EVEN: begin
        acc_ctrl.add = 1'b1;
        state_d      = ST_ADD_ODD;
      end
      ST_ADD_ODD: begin
        acc_ctrl.add     = 1'b1;
        acc_ctrl.sel_odd = 1'b1;
        state_d          = last_q ? ST_SCALE_MAG : ST_IDLE;
      end
      ST_SCALE_MAG: begin
        scale_ctrl.mag_en = 1'b1;
        state_d           = ST_SCALE_MUL;
      end
      ST_SCALE_MUL: begin
        scale_ctrl.mul_en = 1'b1;
        state_d           = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit_load      = 1'b1;
          acc_ctrl.clear = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) last_q <= in_item_i.last;
  end

  // ---------------- lanes ----------------
  idqm_lane u_lane_even (
    .clk_i        (clk_i),
    .ctrl_i       (lane_ctrl),
    .act_i        (in_item_i.act_even),
    .weight_i     (in_item_i.packed_weight[NIBBLE_W-1:0]),
    .zero_point_i (zp_sel),
    .scale_i      (in_item_i.group_scale),
    .keep_i       (1'b1),
    .term_o       (term_even)
  );

  idqm_lane u_lane_odd (
    .clk_i        (clk_i),
    .ctrl_i       (lane_ctrl),
    .act_i        (in_item_i.act_odd),
    .weight_i     (in_item_i.packed_weight[2*NIBBLE_W-1:NIBBLE_W]),
    .zero_point_i (zp_sel),
    .scale_i      (in_item_i.group_scale),
    .keep_i       (in_item_i.odd_valid),
    .term_o       (term_odd)
  );

  // ---------------- merge and final scale ----------------
  idqm_acc #(
    .ACC_BITS (ACC_BITS)
  ) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (acc_ctrl),
    .term_even_i (term_even),
    .term_odd_i  (term_odd),
    .acc_o       (acc_val)
  );

  idqm_scale #(
    .ACC_BITS (ACC_BITS)
  ) u_scale (
    .clk_i       (clk_i),
    .ctrl_i      (scale_ctrl),
    .acc_i       (acc_val),
    .act_scale_i (act_scale_q),
    .result_o    (scale_result),
    .saturated_o (scale_sat)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_item_q.result    <= signed'(scale_result);
      out_item_q.saturated <= scale_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------- checks ----------------
  `IDQM_ASSERT_NEXT(a_accept_starts_mul, in_accept, state_q == ST_MUL, "item accepted but lanes not started")
  `IDQM_ASSERT_NEXT(a_emit_clears_acc, emit_load, acc_val == '0, "accumulator not cleared after result")
  `IDQM_ASSERT_NOW(a_result_only_from_emit, $rose(out_valid_q), $past(state_q == ST_EMIT), "result without final step")
  `IDQM_ASSERT_NOW(a_sat_is_rail, emit_load && scale_sat, scale_result == Q16_MAX || scale_result == Q16_MIN, "saturated result not at a rail")

endmodule

`default_nettype wire

// ----- sim/tb_int4_group_dequant_mac.sv -----
// Self-checking testbench for int4_group_dequant_mac: a directed table, then random K runs.
// Results are predicted in-bench and checked in order. Register writes go through APB and are read back.
// Depends on idqm_pkg and the int4_group_dequant_mac RTL.
module tb_int4_group_dequant_mac;
  import idqm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_DIR         = 22;
  localparam int SETTLE_CYCLES   = 16;
  localparam int ITEMS_PER_PHASE = 292;
  localparam longint ACC_MAX = longint'((64'd1 << (ACC_BITS_DEF - 1)) - 64'd1);
  localparam longint ACC_MIN = -ACC_MAX - 1;

  typedef struct packed {
    logic        zp_mode;
    logic [23:0] act_scale;
    in_item_t    item;
    logic        pinned;      // expected result typed in below
    logic [31:0] exp_result;
    logic        exp_sat;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  in_item_t           in_item_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  out_item_t          out_item_o;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [PADDR_W-1:0] paddr        = '0;
  logic [31:0]        pwdata       = '0;
  logic [31:0]        prdata;
  logic               pready;

  // predictor state
  longint      dot_acc   = 0;
  logic        zp_mode   = 1'b0;
  logic [23:0] act_scale = ACT_SCALE_RESET;
  out_item_t   pending_dots[$];

  int err_count      = 0;
  int send_idle_pct  = 37;
  int recv_stall_pct = 87;

  // act_e act_o weights odd scale zp last
  dir_row_t dir_table [NUM_DIR] = '{
    '{0, 24'h010000, '{8'h01, 8'h00, 8'h09, 0, 24'h010000, 12'h000, 1}, 1, 32'h00010000, 0},
    '{0, 24'h010000, '{8'h00, 8'h00, 8'h00, 1, 24'hFFFFFF, 12'hFFF, 1}, 1, 32'h00000000, 0},
    '{0, 24'h010000, '{8'h80, 8'h80, 8'h00, 1, 24'hFFFFFF, 12'h000, 1}, 1, 32'h7FFFFFFF, 1},
    '{0, 24'h010000, '{8'h7F, 8'h7F, 8'h00, 1, 24'hFFFFFF, 12'hFFF, 1}, 1, 32'h80000000, 1},
    // odd lane masked off
    '{0, 24'h010000, '{8'h00, 8'h7F, 8'hF0, 0, 24'hFFFFFF, 12'h000, 1}, 1, 32'h00000000, 0},
    '{0, 24'h010000, '{8'hFF, 8'h80, 8'h09, 0, 24'h010000, 12'h000, 1}, 1, 32'hFFFF0000, 0},
    '{0, 24'h010000, '{8'h7F, 8'h80, 8'hFF, 1, 24'h003039, 12'hABC, 0}, 0, 32'h0, 0},
    '{0, 24'h010000, '{8'hF9, 8'h05, 8'h3C, 1, 24'h000001, 12'h000, 0}, 0, 32'h0, 0},
    '{0, 24'h010000, '{8'h64, 8'h9C, 8'h5A, 1, 24'h010000, 12'h000, 1}, 0, 32'h0, 0},
    // per-group zero point, zp above weight
    '{1, 24'h010000, '{8'h01, 8'h00, 8'h00, 0, 24'h000001, 12'hFFF, 1}, 0, 32'h0, 0},
    '{1, 24'h010000, '{8'h80, 8'h80, 8'h00, 1, 24'hFFFFFF, 12'hFFF, 1}, 1, 32'h7FFFFFFF, 1},
    '{1, 24'h010000, '{8'h7F, 8'h7F, 8'hFF, 1, 24'hFFFFFF, 12'h000, 1}, 1, 32'h7FFFFFFF, 1},
    '{1, 24'h010000, '{8'h7F, 8'h80, 8'h88, 1, 24'hFFFFFF, 12'h800, 1}, 1, 32'h00000000, 0},
    '{1, 24'h010000, '{8'hFD, 8'h09, 8'h71, 1, 24'h123456, 12'h1A5, 1}, 0, 32'h0, 0},
    // zero activation scale
    '{1, 24'h000000, '{8'h80, 8'h80, 8'h00, 1, 24'hFFFFFF, 12'hFFF, 1}, 1, 32'h00000000, 0},
    '{1, 24'h000000, '{8'h33, 8'hC4, 8'hE7, 1, 24'h0ABCDE, 12'h3FF, 0}, 0, 32'h0, 0},
    '{1, 24'h000000, '{8'h11, 8'h22, 8'h33, 1, 24'h00FFFF, 12'h555, 1}, 1, 32'h00000000, 0},
    '{0, 24'hFFFFFF, '{8'h01, 8'h00, 8'h09, 0, 24'h000001, 12'h000, 1}, 0, 32'h0, 0},
    '{0, 24'hFFFFFF, '{8'h80, 8'h80, 8'h00, 1, 24'hFFFFFF, 12'h000, 1}, 1, 32'h7FFFFFFF, 1},
    '{0, 24'hFFFFFF, '{8'hFF, 8'h00, 8'h09, 0, 24'h000001, 12'h000, 1}, 0, 32'h0, 0},
    '{0, 24'h000001, '{8'h7F, 8'h7F, 8'hFF, 1, 24'hFFFFFF, 12'h000, 1}, 0, 32'h0, 0},
    '{0, 24'h000001, '{8'h80, 8'h7F, 8'h0F, 1, 24'hFFFFFF, 12'hFFF, 1}, 0, 32'h0, 0}
  };

  int4_group_dequant_mac uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint pair_term(input logic signed [7:0] x, input logic [3:0] w,
                                       input logic [11:0] zp, input logic [23:0] scl);
    longint diff;
    diff = longint'({w, 8'h00}) - longint'(zp);
    return longint'(x) * diff * longint'(scl);
  endfunction

  function automatic void acc_add(input longint t);
    if (t > 0 && dot_acc > ACC_MAX - t) begin
      dot_acc = ACC_MAX;
    end else if (t < 0 && dot_acc < ACC_MIN - t) begin
      dot_acc = ACC_MIN;
    end else begin
      dot_acc = dot_acc + t;
    end
  endfunction

  // folds one pair into the running sum; returns 1 with the Q16.16 result on last
  function automatic bit dot_step(input in_item_t it, output out_item_t res);
    logic [11:0] zp_eff;
    logic        neg;
    logic        sat;
    logic [63:0] mag, hi, lo, q;
    zp_eff = zp_mode ? it.group_zero_point : ZP_FIXED;
    acc_add(pair_term(it.act_even, it.packed_weight[3:0], zp_eff, it.group_scale));
    if (it.odd_valid) begin
      acc_add(pair_term(it.act_odd, it.packed_weight[7:4], zp_eff, it.group_scale));
    end
    res = '0;
    if (!it.last) return 1'b0;
    neg = dot_acc < 0;
    mag = neg ? 64'd0 - 64'(dot_acc) : 64'(dot_acc);
    // split multiply keeps the product exact: 24+16 fraction bits -> floor at 16
    hi  = {32'd0, mag[63:32]} * {40'd0, act_scale};
    lo  = {32'd0, mag[31:0]} * {40'd0, act_scale};
    sat = 1'b0;
    q   = '0;
    if (hi[63:32] != 32'd0) begin
      sat = 1'b1;
    end else begin
      q = (hi << 8) + (lo >> 24);
      if (neg && lo[23:0] != 24'd0) q = q + 64'd1;
    end
    if (!neg) begin
      if (sat || q > 64'h7FFF_FFFF) begin
        sat = 1'b1;
        res.result = Q16_MAX;
      end else begin
        res.result = q[31:0];
      end
    end else begin
      if (sat || q > 64'h8000_0000) begin
        sat = 1'b1;
        res.result = Q16_MIN;
      end else begin
        res.result = 32'd0 - q[31:0];
      end
    end
    res.saturated = sat;
    dot_acc = 0;
    return 1'b1;
  endfunction

  function automatic in_item_t random_pair(input bit is_last);
    in_item_t it;
    it.act_even      = 8'($urandom_range(0, 255));
    it.act_odd       = 8'($urandom_range(0, 255));
    it.packed_weight = 8'($urandom_range(0, 255));
    it.odd_valid     = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 3))
      0: it.group_scale = 24'($urandom_range(0, 24'hFFFFFF));
      1: it.group_scale = 24'($urandom_range(0, 255));
      2: it.group_scale = 24'($urandom_range(0, 131072));
      default: it.group_scale = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
    endcase
    if ($urandom_range(0, 1)) begin
      it.group_zero_point = 12'($urandom_range(0, 4095));
    end else begin
      it.group_zero_point = 12'($urandom_range(1792, 2304));
    end
    it.last = is_last;
    return it;
  endfunction

  task automatic note_mismatch(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // tasks below start and end on a falling edge
  task automatic send_pair(input in_item_t it, input bit pinned, input out_item_t pin_val);
    out_item_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (dot_step(it, want)) pending_dots.push_back(pinned ? pin_val : want);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_dots.size() != 0) @(posedge clk_i);
    // a non-last item may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // write, then read back on a back-to-back transfer
  task automatic reg_write_check(input logic idx, input logic [31:0] data);
    logic [31:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_USE_ZP) begin
      zp_mode = data[0];
      want    = {31'd0, data[0]};
    end else begin
      act_scale = data[23:0];
      want      = {8'd0, data[23:0]};
    end
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      note_mismatch($sformatf("reg %0d readback got %h want %h", idx, prdata, want));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_dots.size() == 0) begin
        note_mismatch($sformatf("unexpected result %h sat %b",
                                out_item_o.result, out_item_o.saturated));
      end else begin
        want = pending_dots.pop_front();
        if (out_item_o.result !== want.result || out_item_o.saturated !== want.saturated) begin
          note_mismatch($sformatf("result got %h sat %b, want %h sat %b",
                                  out_item_o.result, out_item_o.saturated,
                                  want.result, want.saturated));
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t    row;
    out_item_t   pin;
    logic [23:0] scale_sel;
    int          sent;
    int          len;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NUM_DIR; i++) begin
      row = dir_table[i];
      if (row.zp_mode != zp_mode || row.act_scale != act_scale) begin
        drain_results();
        if (row.zp_mode != zp_mode) reg_write_check(REG_USE_ZP, {31'd0, row.zp_mode});
        if (row.act_scale != act_scale) begin
          reg_write_check(REG_ACT_SCALE, {8'd0, row.act_scale});
        end
      end
      pin.result    = row.exp_result;
      pin.saturated = row.exp_sat;
      send_pair(row.item, row.pinned, pin);
    end

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct  = (ph < 2) ? 37 : (ph < 4) ? 87 : 0;
      recv_stall_pct = (ph < 2) ? 87 : (ph < 4) ? 37 : 0;
      case (ph)
        0: scale_sel = 24'($urandom_range(0, 24'hFFFFFF));
        1: scale_sel = 24'hFFFFFF;
        2: scale_sel = 24'h000001;
        3: scale_sel = 24'($urandom_range(0, 1 << 18));
        4: scale_sel = ACT_SCALE_RESET;
        default: scale_sel = 24'($urandom_range(1 << 12, 1 << 20));
      endcase
      drain_results();
      reg_write_check(REG_USE_ZP, {31'd0, ~ph[0]});
      reg_write_check(REG_ACT_SCALE, {8'd0, scale_sel});
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 49) == 0) drain_results();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          send_pair(random_pair(k == len - 1), 1'b0, '0);
          sent++;
        end
      end
    end

    drain_results();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/idqm_pkg.sv
hdl/idqm_lane.sv
hdl/idqm_acc.sv
hdl/idqm_scale.sv
hdl/int4_group_dequant_mac.sv
sim/tb_int4_group_dequant_mac.sv
